// ===== rtl/core/mnsm_pkg.sv =====
// Shared types and constants for the mutual nearest signature match core.
// No dependencies; imported by mnsm_div and the top level.
package mnsm_pkg;

  localparam int unsigned MAX_TIPS = 16;
  localparam int unsigned MAX_DIM  = 64;
  localparam int unsigned RESULT_LIMIT = 16;

  localparam int unsigned TIP_W   = $clog2(MAX_TIPS);
  localparam int unsigned ELEM_W  = $clog2(MAX_DIM);
  localparam int unsigned ADDR_W  = TIP_W + ELEM_W;
  localparam int unsigned DEPTH   = MAX_TIPS * MAX_DIM;
  localparam int unsigned CNT_W   = 5;
  localparam int unsigned LEN_W   = 7;
  localparam int unsigned SIG_W   = 32;
  localparam int unsigned FRAC_W  = 16;
  localparam int unsigned QUO_W   = SIG_W + FRAC_W;
  localparam int unsigned SUM_W   = 64;
  localparam int unsigned STEP_W  = $clog2(QUO_W + 1);

  // operation codes
  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_RUN  = 1'b1;
  // set select codes
  localparam logic SET_A = 1'b0;
  localparam logic SET_B = 1'b1;

  // register indexes on the APB port
  localparam logic [1:0] REG_TIP_COUNT_A = 2'd0;
  localparam logic [1:0] REG_TIP_COUNT_B = 2'd1;
  localparam logic [1:0] REG_SIG_LENGTH  = 2'd2;

  typedef struct packed {
    logic              operation;
    logic              set_select;
    logic [3:0]        tip_index;
    logic [5:0]        element_index;
    logic [SIG_W-1:0]  signature_value;
    logic              tip_is_pair;
  } mnsm_in_t;

  typedef struct packed {
    logic       match_valid;
    logic [3:0] index_a;
    logic [3:0] index_b;
    logic       match_is_pair;
    logic       last;
  } mnsm_out_t;

endpackage

// ===== rtl/core/mnsm_ram.sv =====
// Generic single write port, single read port RAM with registered read.
// No dependencies.
module mnsm_ram #(
  parameter int unsigned WIDTH = 32,
  parameter int unsigned DEPTH = 1024
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/mnsm_div.sv =====
// Restoring divider, one quotient bit per cycle: (diff << 16) / divisor.
// Depends on mnsm_pkg.
module mnsm_div (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        start_i,
  input  logic [mnsm_pkg::QUO_W-1:0]  dividend_i,
  input  logic [mnsm_pkg::SIG_W-1:0]  divisor_i,
  output logic                        busy_o,
  output logic                        done_o,
  output logic [mnsm_pkg::QUO_W-1:0]  quotient_o
);
  import mnsm_pkg::*;

  logic              busy_q, busy_d;
  logic              done_q, done_d;
  logic [STEP_W-1:0] cnt_q, cnt_d;
  logic [QUO_W-1:0]  quo_q, quo_d;
  logic [SIG_W-1:0]  rem_q, rem_d;
  logic [SIG_W-1:0]  div_q, div_d;
  logic [SIG_W:0]    part;
  logic              qbit;

  // one restoring step
  assign part = {rem_q, quo_q[QUO_W-1]};
  assign qbit = (part >= {1'b0, div_q});

  always_comb begin
    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    quo_d  = quo_q;
    rem_d  = rem_q;
    div_d  = div_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = STEP_W'(QUO_W);
      quo_d  = dividend_i;
      rem_d  = '0;
      div_d  = divisor_i;
    end else if (busy_q) begin
      rem_d = qbit ? SIG_W'(part - {1'b0, div_q}) : part[SIG_W-1:0];
      quo_d = {quo_q[QUO_W-2:0], qbit};
      cnt_d = cnt_q - STEP_W'(1);
      if (cnt_q == STEP_W'(1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    quo_q <= quo_d;
    rem_q <= rem_d;
    div_q <= div_d;
  end

  assign busy_o     = busy_q;
  assign done_o     = done_q;
  assign quotient_o = quo_q;

  // remainder stays below the divisor while stepping
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !start_i |=> rem_q < div_q)
    else $error("divider remainder out of range");

  // done is a single pulse after the last step
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_q |-> !busy_q)
    else $error("divider done while still busy");

  // no restart while a division runs
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q |-> !start_i)
    else $error("divider restarted while busy");

endmodule

// ===== rtl/core/mutual_nearest_signature_match_core.sv =====
// Top level of the mutual nearest signature match core: sequencer, APB
// registers, signature RAMs. Depends on mnsm_pkg, mnsm_ram and mnsm_div.
//
//  channel   signals                         direction  accepted when
//  item      start_i, item_i, busy_o         in         start_i && !busy_o
//  result    result_valid_o, result_o        out        every strobe cycle
//  config    psel/penable/pwrite/paddr/...   in         psel&penable&pwrite&pready
//
// A load beat is written at the edge that accepts it; busy_o stays low.
// A run walks every candidate of the row's pair kind element by element:
// per element a registered RAM read and, where the reference element is
// non-zero, a serial division of 48 steps followed by a done pulse. The
// shared divider sets the run time.
// Results strobe for one cycle each; the receiver cannot stall.
// Reset clears config and control registers; RAMs and datapath are not reset.
module mutual_nearest_signature_match_core (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  output logic                busy_o,
  input  mnsm_pkg::mnsm_in_t  item_i,
  output logic                result_valid_o,
  output mnsm_pkg::mnsm_out_t result_o,
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [3:0]          paddr,
  input  logic [31:0]         pwdata,
  output logic [31:0]         prdata,
  output logic                pready
);
  import mnsm_pkg::*;

  typedef enum logic [8:0] {
    S_IDLE   = 9'b000000001,
    S_ROW    = 9'b000000010,
    S_CAND   = 9'b000000100,
    S_ELEM   = 9'b000001000,
    S_WAIT   = 9'b000010000,
    S_DIV    = 9'b000100000,
    S_CMP    = 9'b001000000,
    S_DECIDE = 9'b010000000,
    S_FIN    = 9'b100000000
  } state_e;

  state_e state_q, state_d;

  // configuration registers
  logic [CNT_W-1:0] cnt_a_q, cnt_b_q;
  logic [LEN_W-1:0] len_q;
  logic             cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_a_q <= '0;
      cnt_b_q <= '0;
      len_q   <= LEN_W'(MAX_DIM);
    end else if (cfg_we) begin
      unique case (paddr[3:2])
        REG_TIP_COUNT_A: cnt_a_q <= pwdata[CNT_W-1:0];
        REG_TIP_COUNT_B: cnt_b_q <= pwdata[CNT_W-1:0];
        REG_SIG_LENGTH:  len_q   <= pwdata[LEN_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (paddr[3:2])
      REG_TIP_COUNT_A: prdata = 32'(cnt_a_q);
      REG_TIP_COUNT_B: prdata = 32'(cnt_b_q);
      REG_SIG_LENGTH:  prdata = 32'(len_q);
      default:         prdata = '0;
    endcase
  end

  // clamped counts
  logic [CNT_W-1:0] na, nb;
  logic [LEN_W-1:0] len;
  assign na  = (cnt_a_q > CNT_W'(MAX_TIPS)) ? CNT_W'(MAX_TIPS) : cnt_a_q;
  assign nb  = (cnt_b_q > CNT_W'(MAX_TIPS)) ? CNT_W'(MAX_TIPS) : cnt_b_q;
  assign len = (len_q > LEN_W'(MAX_DIM)) ? LEN_W'(MAX_DIM) : len_q;

  // load beats
  logic accept, load, we_a, we_b;
  logic [ADDR_W-1:0] waddr;
  assign accept = start_i && !busy_o;
  assign load   = accept && (item_i.operation == OP_LOAD);
  assign we_a   = load && (item_i.set_select == SET_A);
  assign we_b   = load && (item_i.set_select == SET_B);
  assign waddr  = {item_i.tip_index[TIP_W-1:0], item_i.element_index[ELEM_W-1:0]};

  logic [MAX_TIPS-1:0] pair_a_q, pair_b_q;
  always_ff @(posedge clk_i) begin
    if (we_a && item_i.element_index == '0) begin
      pair_a_q[item_i.tip_index[TIP_W-1:0]] <= item_i.tip_is_pair;
    end
    if (we_b && item_i.element_index == '0) begin
      pair_b_q[item_i.tip_index[TIP_W-1:0]] <= item_i.tip_is_pair;
    end
  end

  // sequencer registers
  logic             rev_q, rev_d;
  logic [CNT_W-1:0] i_q, i_d, c_q, c_d, bidx_q, bidx_d;
  logic [TIP_W-1:0] bj_q, bj_d;
  logic [LEN_W-1:0] e_q, e_d;
  logic [SUM_W-1:0] sum_q, sum_d, best_q, best_d;
  logic             found_q, found_d;
  logic [CNT_W-1:0] emitted_q, emitted_d;
  logic             pend_q, pend_d;
  mnsm_out_t        pend_res_q, pend_res_d;
  logic             res_valid_q, res_valid_d;
  mnsm_out_t        res_q, res_d;

  // RAM read addresses follow the sequencer registers
  logic [TIP_W-1:0]  tip_a, tip_b;
  logic [ADDR_W-1:0] raddr_a, raddr_b;
  logic [SIG_W-1:0]  rdata_a, rdata_b;
  assign tip_a   = rev_q ? c_q[TIP_W-1:0] : i_q[TIP_W-1:0];
  assign tip_b   = rev_q ? bj_q : c_q[TIP_W-1:0];
  assign raddr_a = {tip_a, e_q[ELEM_W-1:0]};
  assign raddr_b = {tip_b, e_q[ELEM_W-1:0]};

  mnsm_ram #(.WIDTH(SIG_W), .DEPTH(DEPTH)) u_ram_a (
    .clk_i   (clk_i),
    .we_i    (we_a),
    .waddr_i (waddr),
    .wdata_i (item_i.signature_value),
    .raddr_i (raddr_a),
    .rdata_o (rdata_a)
  );

  mnsm_ram #(.WIDTH(SIG_W), .DEPTH(DEPTH)) u_ram_b (
    .clk_i   (clk_i),
    .we_i    (we_b),
    .waddr_i (waddr),
    .wdata_i (item_i.signature_value),
    .raddr_i (raddr_b),
    .rdata_o (rdata_b)
  );

  // element terms: x is the reference side, y the candidate side
  logic [SIG_W-1:0] x, y, diff;
  assign x    = rev_q ? rdata_b : rdata_a;
  assign y    = rev_q ? rdata_a : rdata_b;
  assign diff = (x > y) ? x - y : y - x;

  logic             div_start, div_busy, div_done;
  logic [QUO_W-1:0] quo;
  mnsm_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (div_start),
    .dividend_i ({diff, FRAC_W'(0)}),
    .divisor_i  (x),
    .busy_o     (div_busy),
    .done_o     (div_done),
    .quotient_o (quo)
  );

  logic [SUM_W:0]   sum_ext;
  logic [SUM_W-1:0] sum_sat;
  assign sum_ext = {1'b0, sum_q} + (SUM_W+1)'(quo);
  assign sum_sat = sum_ext[SUM_W] ? '1 : sum_ext[SUM_W-1:0];

  logic             cand_kind, row_kind;
  logic [CNT_W-1:0] cand_lim;
  logic [LEN_W-1:0] e_nxt;
  assign row_kind  = pair_a_q[i_q[TIP_W-1:0]];
  assign cand_kind = rev_q ? pair_a_q[c_q[TIP_W-1:0]] : pair_b_q[c_q[TIP_W-1:0]];
  assign cand_lim  = rev_q ? na : nb;
  assign e_nxt     = e_q + LEN_W'(1);

  // sequencer
  always_comb begin
    state_d     = state_q;
    rev_d       = rev_q;
    i_d         = i_q;
    c_d         = c_q;
    bidx_d      = bidx_q;
    bj_d        = bj_q;
    e_d         = e_q;
    sum_d       = sum_q;
    best_d      = best_q;
    found_d     = found_q;
    emitted_d   = emitted_q;
    pend_d      = pend_q;
    pend_res_d  = pend_res_q;
    res_valid_d = 1'b0;
    res_d       = res_q;
    div_start   = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (accept && item_i.operation == OP_RUN) begin
          i_d       = '0;
          emitted_d = '0;
          pend_d    = 1'b0;
          state_d   = S_ROW;
        end
      end
      S_ROW: begin
        if (i_q < na && (emitted_q + CNT_W'(pend_q)) < CNT_W'(RESULT_LIMIT)) begin
          rev_d   = 1'b0;
          c_d     = '0;
          best_d  = '1;
          found_d = 1'b0;
          state_d = S_CAND;
        end else begin
          state_d = S_FIN;
        end
      end
      S_CAND: begin
        if (c_q >= cand_lim) begin
          state_d = S_DECIDE;
        end else if (cand_kind != row_kind) begin
          c_d = c_q + CNT_W'(1);
        end else begin
          sum_d   = '0;
          e_d     = '0;
          state_d = (len == '0) ? S_CMP : S_ELEM;
        end
      end
      S_ELEM: begin
        state_d = S_WAIT;
      end
      S_WAIT: begin
        if (x != '0) begin
          div_start = 1'b1;
          state_d   = S_DIV;
        end else begin
          if (diff != '0) sum_d = '1;
          e_d     = e_nxt;
          state_d = (e_nxt == len) ? S_CMP : S_ELEM;
        end
      end
      S_DIV: begin
        if (div_done) begin
          sum_d   = sum_sat;
          e_d     = e_nxt;
          state_d = (e_nxt == len) ? S_CMP : S_ELEM;
        end
      end
      S_CMP: begin
        if (sum_q != '1 && sum_q < best_q) begin
          best_d  = sum_q;
          bidx_d  = c_q;
          found_d = 1'b1;
        end
        c_d     = c_q + CNT_W'(1);
        state_d = S_CAND;
      end
      S_DECIDE: begin
        if (!rev_q && found_q) begin
          bj_d    = bidx_q[TIP_W-1:0];
          rev_d   = 1'b1;
          c_d     = '0;
          best_d  = '1;
          found_d = 1'b0;
          state_d = S_CAND;
        end else begin
          if (rev_q && found_q && bidx_q == i_q) begin
            // flush the held match; a newer one follows it
            if (pend_q) begin
              res_valid_d = 1'b1;
              res_d       = pend_res_q;
              emitted_d   = emitted_q + CNT_W'(1);
            end
            pend_d                   = 1'b1;
            pend_res_d.match_valid   = 1'b1;
            pend_res_d.index_a       = 4'(i_q);
            pend_res_d.index_b       = 4'(bj_q);
            pend_res_d.match_is_pair = row_kind;
            pend_res_d.last          = 1'b0;
          end
          i_d     = i_q + CNT_W'(1);
          state_d = S_ROW;
        end
      end
      S_FIN: begin
        res_valid_d = 1'b1;
        if (pend_q) begin
          res_d = pend_res_q;
        end else begin
          res_d = '0;
        end
        res_d.last = 1'b1;
        state_d    = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      rev_q       <= 1'b0;
      i_q         <= '0;
      c_q         <= '0;
      e_q         <= '0;
      found_q     <= 1'b0;
      emitted_q   <= '0;
      pend_q      <= 1'b0;
      res_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      rev_q       <= rev_d;
      i_q         <= i_d;
      c_q         <= c_d;
      e_q         <= e_d;
      found_q     <= found_d;
      emitted_q   <= emitted_d;
      pend_q      <= pend_d;
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    bidx_q     <= bidx_d;
    bj_q       <= bj_d;
    sum_q      <= sum_d;
    best_q     <= best_d;
    pend_res_q <= pend_res_d;
    res_q      <= res_d;
  end

  assign busy_o         = (state_q != S_IDLE);
  assign result_valid_o = res_valid_q;
  assign result_o       = res_q;

  // an empty-run beat is always the final one
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && !res_q.match_valid |-> res_q.last)
    else $error("invalid result without last");

  // nothing follows the final beat of a run directly
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_q && res_q.last |=> !res_valid_q)
    else $error("beat straight after last");

  // the divider is busy or just finished while the sequencer waits on it
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> div_busy || div_done)
    else $error("waiting on an idle divider");

  // never more beats than the result limit in one run
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    emitted_q + CNT_W'(pend_q) <= CNT_W'(RESULT_LIMIT))
    else $error("result limit exceeded");

endmodule
